[design/rip_pkg.sv]
// ----------------------------------------------------------------------------
// Range image projection package
// Shared widths, result codes, register indexes, state types and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rip_pkg;

   localparam int unsigned COORD_W      = 24;
   localparam int unsigned RANGE_W      = 24;
   localparam int unsigned RING_W       = 8;
   localparam int unsigned COL_W        = 12;
   localparam int unsigned CELL_W       = 20;
   localparam int unsigned STAT_W       = 3;
   localparam int unsigned RATE_W       = 5;
   localparam int unsigned SUM_W        = 48;
   localparam int unsigned REM_W        = 27;
   localparam int unsigned CORDIC_W     = 50;
   localparam int unsigned ANG_W        = 34;
   localparam int unsigned STEP_W       = 5;
   localparam int unsigned CORDIC_STEPS = 31;
   localparam int unsigned ROOT_STEPS   = 24;
   localparam int unsigned CSR_AW       = 4;
   localparam int unsigned CSR_DW       = 32;

   localparam logic [STAT_W-1:0] ST_KEPT        = 3'd0;
   localparam logic [STAT_W-1:0] ST_RANGE_OUT   = 3'd1;
   localparam logic [STAT_W-1:0] ST_RING_OUT    = 3'd2;
   localparam logic [STAT_W-1:0] ST_DOWNSAMPLED = 3'd3;
   localparam logic [STAT_W-1:0] ST_COLUMN_OUT  = 3'd4;
   localparam logic [STAT_W-1:0] ST_OCCUPIED    = 3'd5;
   localparam logic [STAT_W-1:0] ST_CLEARED     = 3'd6;

   localparam logic [RANGE_W-1:0] MIN_RANGE_RESET = 24'd1024;
   localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 24'd1024000;
   localparam logic [RATE_W-1:0]  RATE_RESET      = 5'd1;

   typedef enum logic [1:0] {
      CSR_MIN_RANGE  = 2'd0,
      CSR_MAX_RANGE  = 2'd1,
      CSR_DOWNSAMPLE = 2'd2
   } csr_reg_type;

   typedef enum logic [3:0] {
      TOP_CLEAR, TOP_IDLE, TOP_WAIT, TOP_MULT, TOP_ROUND,
      TOP_WRAP, TOP_INDEX, TOP_OCC, TOP_DONE
   } top_state_type;

   typedef enum logic [1:0] {
      MAG_IDLE, MAG_SQUARE, MAG_ROOT
   } mag_state_type;

   typedef enum logic {
      COR_IDLE, COR_RUN
   } cordic_state_type;

   typedef enum logic [1:0] {
      OCC_IDLE, OCC_CLEAR, OCC_READ, OCC_WRITE
   } occ_state_type;

   typedef struct packed {
      logic clear;
      logic lookup;
   } occ_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic occupied;
   } occ_sts_type;

   typedef struct packed {
      logic done;
      logic range_bad;
      logic ring_skip;
   } mag_sts_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
      logic [31:0] t;
      case (i)
         5'd0:    t = 32'h20000000;
         5'd1:    t = 32'h12E4051D;
         5'd2:    t = 32'h09FB385B;
         5'd3:    t = 32'h051111D4;
         5'd4:    t = 32'h028B0D43;
         5'd5:    t = 32'h0145D7E1;
         5'd6:    t = 32'h00A2F61E;
         5'd7:    t = 32'h00517C55;
         5'd8:    t = 32'h0028BE53;
         5'd9:    t = 32'h00145F2E;
         5'd10:   t = 32'h000A2F98;
         5'd11:   t = 32'h000517CC;
         5'd12:   t = 32'h00028BE6;
         5'd13:   t = 32'h000145F3;
         5'd14:   t = 32'h0000A2F9;
         5'd15:   t = 32'h0000517C;
         5'd16:   t = 32'h000028BE;
         5'd17:   t = 32'h0000145F;
         5'd18:   t = 32'h00000A2F;
         5'd19:   t = 32'h00000517;
         5'd20:   t = 32'h0000028B;
         5'd21:   t = 32'h00000145;
         5'd22:   t = 32'h000000A2;
         5'd23:   t = 32'h00000051;
         5'd24:   t = 32'h00000028;
         5'd25:   t = 32'h00000014;
         5'd26:   t = 32'h0000000A;
         5'd27:   t = 32'h00000005;
         5'd28:   t = 32'h00000002;
         5'd29:   t = 32'h00000001;
         default: t = 32'h00000000;
      endcase
      return t;
   endfunction

endpackage

[design/rip_req_if.sv]
// ----------------------------------------------------------------------------
// Point request channel
// Valid/ready channel carrying one lidar point or a new-scan command.
// ----------------------------------------------------------------------------
interface rip_req_if;
   import rip_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;
   logic [RING_W-1:0]         ring;

   modport source (output valid, action, point_x, point_y, point_z, ring, input ready);
   modport sink   (input valid, action, point_x, point_y, point_z, ring, output ready);
endinterface

[design/rip_rsp_if.sv]
// ----------------------------------------------------------------------------
// Projection result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface rip_rsp_if;
   import rip_pkg::*;

   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [RING_W-1:0]  row;
   logic [COL_W-1:0]   column;
   logic [RANGE_W-1:0] range;
   logic [CELL_W-1:0]  cell_index;

   modport source (output valid, status, row, column, range, cell_index, input ready);
   modport sink   (input valid, status, row, column, range, cell_index, output ready);
endinterface

[design/rip_mag.sv]
// ----------------------------------------------------------------------------
// Range magnitude unit
// Sums the squared coordinates on one shared multiplier, takes the square
// root two radicand bits per cycle, and checks the range window and the
// ring downsample remainder one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rip_mag (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [rip_pkg::COORD_W-1:0] x,
   input  logic signed [rip_pkg::COORD_W-1:0] y,
   input  logic signed [rip_pkg::COORD_W-1:0] z,
   input  logic [rip_pkg::RING_W-1:0]         ring,
   input  logic [rip_pkg::RATE_W-1:0]         rate,
   input  logic [rip_pkg::RANGE_W-1:0]        min_range,
   input  logic [rip_pkg::RANGE_W-1:0]        max_range,
   output rip_pkg::mag_sts_type               sts,
   output logic [rip_pkg::RANGE_W-1:0]        rng
);
   import rip_pkg::*;

   mag_state_type        state_ff, state_in;
   logic [2:0]           sq_cnt_ff, sq_cnt_in;
   logic [STEP_W-1:0]    rt_cnt_ff, rt_cnt_in;
   logic [COORD_W-1:0]   ax_ff, ay_ff, az_ff, amin_ff, amax_ff;
   logic [COORD_W-1:0]   ax_in, ay_in, az_in, amin_in, amax_in;
   logic [SUM_W-1:0]     prod_ff, prod_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SUM_W-1:0]     minsq_ff, minsq_in;
   logic [SUM_W-1:0]     maxsq_ff, maxsq_in;
   logic [SUM_W-1:0]     rad_ff, rad_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [RANGE_W-1:0]   root_ff, root_in;
   logic [RING_W-1:0]    md_ff, md_in;
   logic [RATE_W-1:0]    mrem_ff, mrem_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic                 done_ff, done_in;
   logic [COORD_W-1:0]   op;
   logic [REM_W-1:0]     rem_sh;
   logic [REM_W-1:0]     trial;
   logic [RATE_W:0]      mod_t;
   logic [RATE_W-1:0]    rate_eff;
   logic                 round_up;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MAG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sq_cnt_ff <= sq_cnt_in;
      rt_cnt_ff <= rt_cnt_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      az_ff     <= az_in;
      amin_ff   <= amin_in;
      amax_ff   <= amax_in;
      prod_ff   <= prod_in;
      sum_ff    <= sum_in;
      minsq_ff  <= minsq_in;
      maxsq_ff  <= maxsq_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      md_ff     <= md_in;
      mrem_ff   <= mrem_in;
      rate_ff   <= rate_in;
   end

   always_comb begin
      case (sq_cnt_ff)
         3'd0:    op = ax_ff;
         3'd1:    op = ay_ff;
         3'd2:    op = az_ff;
         3'd3:    op = amin_ff;
         3'd4:    op = amax_ff;
         default: op = '0;
      endcase
      prod_in  = SUM_W'(op) * SUM_W'(op);
      rem_sh   = {rem_ff[REM_W-3:0], rad_ff[SUM_W-1:SUM_W-2]};
      trial    = {1'b0, root_ff, 2'b01};
      rate_eff = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
      mod_t    = {mrem_ff, md_ff[RING_W-1]};
   end

   always_comb begin
      state_in  = state_ff;
      sq_cnt_in = sq_cnt_ff;
      rt_cnt_in = rt_cnt_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      az_in     = az_ff;
      amin_in   = amin_ff;
      amax_in   = amax_ff;
      sum_in    = sum_ff;
      minsq_in  = minsq_ff;
      maxsq_in  = maxsq_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      md_in     = md_ff;
      mrem_in   = mrem_ff;
      rate_in   = rate_ff;
      done_in   = 1'b0;
      case (state_ff)
         MAG_IDLE: begin
            if (start) begin
               // The magnitude of the most negative coordinate still fits unsigned.
               ax_in     = x[COORD_W-1] ? (~x + 1'b1) : x;
               ay_in     = y[COORD_W-1] ? (~y + 1'b1) : y;
               az_in     = z[COORD_W-1] ? (~z + 1'b1) : z;
               amin_in   = min_range;
               amax_in   = max_range;
               md_in     = ring;
               rate_in   = rate;
               sum_in    = '0;
               sq_cnt_in = '0;
               state_in  = MAG_SQUARE;
            end
         end
         MAG_SQUARE: begin
            sq_cnt_in = sq_cnt_ff + 1'b1;
            case (sq_cnt_ff)
               3'd1, 3'd2, 3'd3: sum_in = sum_ff + prod_ff;
               3'd4: minsq_in = prod_ff;
               3'd5: begin
                  maxsq_in  = prod_ff;
                  rad_in    = sum_ff;
                  rem_in    = '0;
                  root_in   = '0;
                  mrem_in   = '0;
                  rt_cnt_in = '0;
                  state_in  = MAG_ROOT;
               end
               default: ;
            endcase
         end
         MAG_ROOT: begin
            rad_in = {rad_ff[SUM_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[RANGE_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[RANGE_W-2:0], 1'b0};
            end
            if (rt_cnt_ff < STEP_W'(RING_W)) begin
               md_in = {md_ff[RING_W-2:0], 1'b0};
               if (mod_t >= {1'b0, rate_eff}) begin
                  mrem_in = RATE_W'(mod_t - {1'b0, rate_eff});
               end else begin
                  mrem_in = mod_t[RATE_W-1:0];
               end
            end
            rt_cnt_in = rt_cnt_ff + 1'b1;
            if (rt_cnt_ff == STEP_W'(ROOT_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = MAG_IDLE;
            end
         end
         default: state_in = MAG_IDLE;
      endcase
   end

   // The remainder exceeds the floor root exactly when the range rounds up.
   always_comb begin
      round_up = rem_ff > REM_W'(root_ff);
      if (round_up && (root_ff != '1)) begin
         rng = root_ff + 1'b1;
      end else begin
         rng = root_ff;
      end
      sts.done      = done_ff;
      sts.range_bad = (sum_ff < minsq_ff) || (sum_ff > maxsq_ff);
      sts.ring_skip = (mrem_ff != '0);
   end

endmodule

[design/rip_cordic.sv]
// ----------------------------------------------------------------------------
// CORDIC arctangent unit
// Vectoring CORDIC, one micro-rotation per cycle, producing atan2(x, y) as
// a binary angle in units of 2^-32 turn.
// ----------------------------------------------------------------------------
module rip_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [rip_pkg::COORD_W-1:0] x,
   input  logic signed [rip_pkg::COORD_W-1:0] y,
   output logic                               done,
   output logic signed [rip_pkg::ANG_W-1:0]   angle
);
   import rip_pkg::*;

   localparam logic signed [ANG_W-1:0] ANG_QUARTER = 34'sd1073741824;
   localparam logic signed [ANG_W-1:0] ANG_HALF    = 34'sd2147483648;
   localparam logic signed [ANG_W-1:0] ANG_FULL    = 34'sd4294967296;

   cordic_state_type            state_ff, state_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic signed [CORDIC_W-1:0]  h_ff, h_in, v_ff, v_in;
   logic signed [ANG_W-1:0]     z_ff, z_in;
   logic                        done_ff, done_in;
   logic signed [2*COORD_W-1:0] hs, vs;
   logic signed [CORDIC_W-1:0]  h0, v0, h_sh, v_sh;
   logic signed [ANG_W-1:0]     at;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= COR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      h_ff    <= h_in;
      v_ff    <= v_in;
      z_ff    <= z_in;
   end

   always_comb begin
      hs   = {y, {COORD_W{1'b0}}};
      vs   = {x, {COORD_W{1'b0}}};
      h0   = CORDIC_W'(hs);
      v0   = CORDIC_W'(vs);
      h_sh = h_ff >>> step_ff;
      v_sh = v_ff >>> step_ff;
      at   = $signed({2'b00, atan_turn(step_ff)});
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      h_in     = h_ff;
      v_in     = v_ff;
      z_in     = z_ff;
      done_in  = 1'b0;
      case (state_ff)
         COR_IDLE: begin
            if (start) begin
               step_in = '0;
               if ((x == '0) && (y == '0)) begin
                  z_in    = '0;
                  done_in = 1'b1;
               end else begin
                  state_in = COR_RUN;
                  // Rotate a left half-plane vector by a quarter turn first.
                  if (h0 < 0) begin
                     if (v0 >= 0) begin
                        h_in = v0;
                        v_in = -h0;
                        z_in = ANG_QUARTER;
                     end else begin
                        h_in = -v0;
                        v_in = h0;
                        z_in = -ANG_QUARTER;
                     end
                  end else begin
                     h_in = h0;
                     v_in = v0;
                     z_in = '0;
                  end
               end
            end
         end
         COR_RUN: begin
            if (v_ff >= 0) begin
               h_in = h_ff + v_sh;
               v_in = v_ff - h_sh;
               z_in = z_ff + at;
            end else begin
               h_in = h_ff - v_sh;
               v_in = v_ff + h_sh;
               z_in = z_ff - at;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = COR_IDLE;
            end
         end
         default: state_in = COR_IDLE;
      endcase
   end

   always_comb begin
      if (z_ff > ANG_HALF) begin
         angle = z_ff - ANG_FULL;
      end else if (z_ff <= -ANG_HALF) begin
         angle = z_ff + ANG_FULL;
      end else begin
         angle = z_ff;
      end
      done = done_ff;
   end

endmodule

[design/rip_occ.sv]
// ----------------------------------------------------------------------------
// Occupancy bitmap
// One bit per image cell, packed 32 to a memory word. A lookup reads the
// word and sets the bit if it was free; a clear sweeps one word per cycle.
// ----------------------------------------------------------------------------
module rip_occ #(
   parameter int unsigned CELLS = 28800
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rip_pkg::occ_cmd_type             cmd,
   input  logic [rip_pkg::CELL_W-1:0]       cell_addr,
   output rip_pkg::occ_sts_type             sts
);
   import rip_pkg::*;

   localparam int unsigned WORDS = (CELLS + 31) / 32;
   localparam int unsigned AW    = $clog2(WORDS);

   logic [31:0]   mem [WORDS];
   occ_state_type state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [4:0]    bit_ff, bit_in;
   logic [31:0]   rd_data_ff;
   logic          done_ff, done_in;
   logic          occupied_ff, occupied_in;
   logic          wr_en;
   logic [31:0]   wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OCC_CLEAR;
         addr_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         done_ff  <= done_in;
      end
      bit_ff      <= bit_in;
      occupied_ff <= occupied_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= wr_data;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      bit_in      = bit_ff;
      occupied_in = occupied_ff;
      done_in     = 1'b0;
      wr_en       = 1'b0;
      wr_data     = '0;
      case (state_ff)
         OCC_IDLE: begin
            if (cmd.clear) begin
               addr_in  = '0;
               state_in = OCC_CLEAR;
            end else if (cmd.lookup) begin
               addr_in  = cell_addr[AW+4:5];
               bit_in   = cell_addr[4:0];
               state_in = OCC_READ;
            end
         end
         OCC_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == AW'(WORDS - 1)) begin
               done_in  = 1'b1;
               state_in = OCC_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         OCC_READ: state_in = OCC_WRITE;
         OCC_WRITE: begin
            occupied_in = rd_data_ff[bit_ff];
            wr_en       = !rd_data_ff[bit_ff];
            wr_data     = rd_data_ff | (32'd1 << bit_ff);
            done_in     = 1'b1;
            state_in    = OCC_IDLE;
         end
         default: state_in = OCC_IDLE;
      endcase
   end

   assign sts.busy     = (state_ff != OCC_IDLE);
   assign sts.done     = done_ff;
   assign sts.occupied = occupied_ff;

endmodule

[design/range_image_projection_core.sv]
// ----------------------------------------------------------------------------
// Range image projection core
// Projects lidar points onto a ring-by-column range image.
// ----------------------------------------------------------------------------
// Each transfer on req carries a point (action 0) or a new-scan command
// (action 1). Every request yields exactly one transfer on rsp, in order.
// A point's result waits on the 31-step CORDIC loop, with the 24-step square
// root running beside it. One point is in work at a time: the next request
// is taken only once the last result has moved to the output register.
// Points rejected by range, ring or downsample finish sooner, as they skip
// the column and occupancy states.
// A new-scan command clears the occupancy bitmap one 32-bit word per cycle,
// ceil(ROWS*COLUMNS/32) words (900 at the default size), then reports.
// After reset the same clearing pass runs and req.ready stays low until it
// is done; the csr port is live throughout.
// The result sits in an output register: while the receiver stalls, the
// next request is still taken and worked, and waits until the register
// frees up.
// ----------------------------------------------------------------------------
module range_image_projection_core #(
   parameter int unsigned ROWS    = 16,
   parameter int unsigned COLUMNS = 1800
) (
   input  logic                          clock,
   input  logic                          reset,
   rip_req_if.sink                       req,
   rip_rsp_if.source                     rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rip_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [rip_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [rip_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import rip_pkg::*;

   localparam int unsigned CELLS = ROWS * COLUMNS;
   localparam int unsigned P_W   = 48;
   localparam int unsigned C_W   = 18;
   localparam logic signed [P_W-1:0] COLS_P    = P_W'(COLUMNS);
   localparam logic signed [C_W-1:0] COLS_C    = C_W'(COLUMNS);
   localparam logic signed [C_W-1:0] HALF_C    = C_W'(COLUMNS / 2);
   localparam logic signed [ANG_W:0] QUARTER_U = 35'sd1073741824;

   top_state_type              state_ff, state_in;
   logic [RANGE_W-1:0]         min_range_ff, max_range_ff;
   logic [RATE_W-1:0]          rate_ff;
   logic [RING_W-1:0]          ring_ff, ring_in;
   logic [RANGE_W-1:0]         rng_ff, rng_in;
   logic signed [P_W-1:0]      p_ff, p_in;
   logic signed [C_W-1:0]      col_ff, col_in;
   logic [COL_W-1:0]           col12_ff, col12_in;
   logic [CELL_W-1:0]          idx_ff, idx_in;
   logic [STAT_W-1:0]          res_status_ff, res_status_in;
   logic                       report_ff, report_in;
   logic                       mag_seen_ff, mag_seen_in;
   logic                       cor_seen_ff, cor_seen_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]          rsp_status_ff, rsp_status_in;
   logic [RING_W-1:0]          rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]           rsp_col_ff, rsp_col_in;
   logic [RANGE_W-1:0]         rsp_range_ff, rsp_range_in;
   logic [CELL_W-1:0]          rsp_idx_ff, rsp_idx_in;
   logic                       req_xfer, csr_write, start_point;
   mag_sts_type                mag_sts;
   logic [RANGE_W-1:0]         mag_rng;
   logic                       cor_done;
   logic signed [ANG_W-1:0]    cor_angle;
   occ_cmd_type                occ_cmd;
   occ_sts_type                occ_sts;
   logic signed [ANG_W:0]      u;
   logic [P_W-1:0]             p_abs, p_rnd;
   logic signed [C_W-1:0]      r_s, col_w;
   logic                       col_bad;

   assign req_xfer    = req.valid && req.ready;
   assign start_point = req_xfer && !req.action;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff <= MIN_RANGE_RESET;
         max_range_ff <= MAX_RANGE_RESET;
         rate_ff      <= RATE_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            CSR_MIN_RANGE:  min_range_ff <= csr_pwdata[RANGE_W-1:0];
            CSR_MAX_RANGE:  max_range_ff <= csr_pwdata[RANGE_W-1:0];
            CSR_DOWNSAMPLE: rate_ff      <= csr_pwdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_MIN_RANGE:  csr_prdata = CSR_DW'(min_range_ff);
         CSR_MAX_RANGE:  csr_prdata = CSR_DW'(max_range_ff);
         CSR_DOWNSAMPLE: csr_prdata = CSR_DW'(rate_ff);
         default:        csr_prdata = '0;
      endcase
   end

   rip_mag u_mag (
      .clock     (clock),
      .reset     (reset),
      .start     (start_point),
      .x         (req.point_x),
      .y         (req.point_y),
      .z         (req.point_z),
      .ring      (req.ring),
      .rate      (rate_ff),
      .min_range (min_range_ff),
      .max_range (max_range_ff),
      .sts       (mag_sts),
      .rng       (mag_rng)
   );

   rip_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (start_point),
      .x     (req.point_x),
      .y     (req.point_y),
      .done  (cor_done),
      .angle (cor_angle)
   );

   rip_occ #(.CELLS(CELLS)) u_occ (
      .clock     (clock),
      .reset     (reset),
      .cmd       (occ_cmd),
      .cell_addr (idx_ff),
      .sts       (occ_sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_CLEAR;
         report_ff    <= 1'b0;
         mag_seen_ff  <= 1'b0;
         cor_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         report_ff    <= report_in;
         mag_seen_ff  <= mag_seen_in;
         cor_seen_ff  <= cor_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ring_ff       <= ring_in;
      rng_ff        <= rng_in;
      p_ff          <= p_in;
      col_ff        <= col_in;
      col12_ff      <= col12_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_range_ff  <= rsp_range_in;
      rsp_idx_ff    <= rsp_idx_in;
   end

   // Column arithmetic: angle minus a quarter turn, scaled, rounded half away
   // from zero, then mirrored about the image center with one wrap.
   always_comb begin
      u       = ANG_W'(cor_angle) - QUARTER_U;
      p_abs   = p_ff[P_W-1] ? P_W'(-p_ff) : P_W'(p_ff);
      p_rnd   = p_abs + P_W'(64'h80000000);
      r_s     = p_ff[P_W-1] ? -$signed({2'b00, p_rnd[P_W-1:32]})
                            : $signed({2'b00, p_rnd[P_W-1:32]});
      col_w   = (col_ff >= COLS_C) ? (col_ff - COLS_C) : col_ff;
      col_bad = (col_w < 0) || (col_w >= COLS_C);
   end

   always_comb begin
      state_in      = state_ff;
      report_in     = report_ff;
      mag_seen_in   = mag_seen_ff | mag_sts.done;
      cor_seen_in   = cor_seen_ff | cor_done;
      ring_in       = ring_ff;
      rng_in        = rng_ff;
      p_in          = p_ff;
      col_in        = col_ff;
      col12_in      = col12_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_range_in  = rsp_range_ff;
      rsp_idx_in    = rsp_idx_ff;
      occ_cmd       = '0;
      req.ready     = 1'b0;
      case (state_ff)
         TOP_CLEAR: begin
            if (occ_sts.done) begin
               if (report_ff) begin
                  res_status_in = ST_CLEARED;
                  state_in      = TOP_DONE;
               end else begin
                  state_in = TOP_IDLE;
               end
               report_in = 1'b0;
            end
         end
         TOP_IDLE: begin
            req.ready = 1'b1;
            if (req_xfer) begin
               if (req.action) begin
                  occ_cmd.clear = 1'b1;
                  report_in     = 1'b1;
                  state_in      = TOP_CLEAR;
               end else begin
                  ring_in     = req.ring;
                  mag_seen_in = 1'b0;
                  cor_seen_in = 1'b0;
                  state_in    = TOP_WAIT;
               end
            end
         end
         TOP_WAIT: begin
            if (mag_seen_in && cor_seen_in) begin
               rng_in = mag_rng;
               p_in   = P_W'(u) * COLS_P;
               if (mag_sts.range_bad) begin
                  res_status_in = ST_RANGE_OUT;
                  state_in      = TOP_DONE;
               end else if ({1'b0, ring_ff} >= (RING_W + 1)'(ROWS)) begin
                  res_status_in = ST_RING_OUT;
                  state_in      = TOP_DONE;
               end else if (mag_sts.ring_skip) begin
                  res_status_in = ST_DOWNSAMPLED;
                  state_in      = TOP_DONE;
               end else begin
                  state_in = TOP_MULT;
               end
            end
         end
         TOP_MULT: begin
            col_in   = HALF_C - r_s;
            state_in = TOP_ROUND;
         end
         TOP_ROUND: begin
            col_in   = col_w;
            state_in = TOP_WRAP;
         end
         TOP_WRAP: begin
            if (col_bad) begin
               res_status_in = ST_COLUMN_OUT;
               state_in      = TOP_DONE;
            end else begin
               col12_in = col_ff[COL_W-1:0];
               idx_in   = CELL_W'(ring_ff) * CELL_W'(COLUMNS) + CELL_W'(col_ff[COL_W-1:0]);
               state_in = TOP_INDEX;
            end
         end
         TOP_INDEX: begin
            occ_cmd.lookup = 1'b1;
            state_in       = TOP_OCC;
         end
         TOP_OCC: begin
            if (occ_sts.done) begin
               res_status_in = occ_sts.occupied ? ST_OCCUPIED : ST_KEPT;
               state_in      = TOP_DONE;
            end
         end
         TOP_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_row_in    = (res_status_ff == ST_CLEARED) ? '0 : ring_ff;
               rsp_col_in    = ((res_status_ff == ST_KEPT) || (res_status_ff == ST_OCCUPIED))
                               ? col12_ff : '0;
               rsp_range_in  = (res_status_ff == ST_CLEARED) ? '0 : rng_ff;
               rsp_idx_in    = (res_status_ff == ST_KEPT) ? idx_ff : '0;
               state_in      = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.row        = rsp_row_ff;
   assign rsp.column     = rsp_col_ff;
   assign rsp.range      = rsp_range_ff;
   assign rsp.cell_index = rsp_idx_ff;

   a_ready_occ_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !occ_sts.busy)
      else $error("request taken while the occupancy bitmap is busy");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req.ready)
      else $error("second request taken while one is in work");

   a_cleared_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status == ST_CLEARED)) |->
         ((rsp.range == '0) && (rsp.cell_index == '0) && (rsp.row == '0)))
      else $error("new-scan result carries nonzero fields");

   a_kept_column: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status == ST_KEPT)) |->
         ((COL_W + 1)'(rsp.column) < (COL_W + 1)'(COLUMNS)))
      else $error("kept point outside the image columns");

endmodule

[test/range_image_projection_core_tb.sv]
// ----------------------------------------------------------------------------
// Range image projection core testbench
// Drives points and new-scan commands through the request channel. A local
// model of the range test, ring filter, angle-to-column mapping and occupancy
// bitmap predicts every result. The CSR port is set to several range windows
// and downsample rates between phases, and both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module range_image_projection_core_tb;
   import rip_pkg::*;

   localparam int unsigned ROWS    = 16;
   localparam int unsigned COLUMNS = 1800;
   localparam int unsigned CELLS   = ROWS * COLUMNS;
   localparam logic ACT_POINT = 1'b0;
   localparam logic ACT_SCAN  = 1'b1;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int EXPECT_DEPTH   = 16;
   localparam longint ANG_QUARTER = 64'sd1073741824;
   localparam longint ANG_HALF    = 64'sd2147483648;
   localparam longint ANG_FULL    = 64'sd4294967296;

   localparam longint ARCTAN [0:30] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000};

   typedef struct packed {
      logic              action;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic [RING_W-1:0] ring;
   } point_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [RING_W-1:0]  row;
      logic [COL_W-1:0]   column;
      logic [RANGE_W-1:0] range;
      logic [CELL_W-1:0]  cell_index;
   } pixel_type;

   typedef struct packed {
      point_type point;
      logic      typed;
      pixel_type pixel;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   rip_req_if req ();
   rip_rsp_if rsp ();

   range_image_projection_core #(.ROWS(ROWS), .COLUMNS(COLUMNS)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready));

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Local copy of configuration and occupancy.
   logic [23:0] win_min, win_max;
   logic [4:0]  keep_rate;
   bit          cell_taken [CELLS];

   // Expected results in order; the writer and the reader each own a counter.
   pixel_type expect_mem [EXPECT_DEPTH];
   int  expect_wr = 0;
   int  expect_rd = 0;
   int  errors = 0;
   int  points_sent = 0, scans_sent = 0, kept_seen = 0, occupied_seen = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;
   int  rsp_hold = 0;

   initial begin
      req.valid = 1'b0; req.action = ACT_POINT;
      req.point_x = '0; req.point_y = '0; req.point_z = '0; req.ring = '0;
      rsp.ready = 1'b0;
   end

   function automatic longint unsigned root_floor(longint unsigned s);
      longint unsigned res = 0, b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint bearing_turns(longint vx, longint vy);
      longint h, v, z, nh, nv;
      z = 0;
      if (vx == 0 && vy == 0) return 0;
      h = vy * 16777216;
      v = vx * 16777216;
      if (h < 0) begin
         if (v >= 0) begin
            nh = v; nv = -h; z = ANG_QUARTER;
         end else begin
            nh = -v; nv = h; z = -ANG_QUARTER;
         end
         h = nh; v = nv;
      end
      for (int i = 0; i < 31; i++) begin
         if (v >= 0) begin
            nh = h + (v >>> i); nv = v - (h >>> i); z = z + ARCTAN[i];
         end else begin
            nh = h - (v >>> i); nv = v + (h >>> i); z = z - ARCTAN[i];
         end
         h = nh; v = nv;
      end
      if (z > ANG_HALF) z = z - ANG_FULL;
      if (z <= -ANG_HALF) z = z + ANG_FULL;
      return z;
   endfunction

   // Computes the result of one request and updates the occupancy bitmap.
   function automatic pixel_type project_point(point_type pt);
      pixel_type px;
      longint x, y, z, ang, p, r, col, lo, hi;
      longint unsigned s, f, rng, rate;
      int idx;
      px = '0;
      if (pt.action == ACT_SCAN) begin
         foreach (cell_taken[i]) cell_taken[i] = 1'b0;
         px.status = ST_CLEARED;
         return px;
      end
      x = pt.x; y = pt.y; z = pt.z;
      s = x*x + y*y + z*z;
      f = root_floor(s);
      rng = (s > f*f + f) ? f + 1 : f;
      if (rng > 64'hFFFFFF) rng = 64'hFFFFFF;
      px.row = pt.ring;
      px.range = rng[23:0];
      lo = win_min; hi = win_max;
      if (s < lo*lo || s > hi*hi) begin
         px.status = ST_RANGE_OUT;
         return px;
      end
      if (pt.ring >= ROWS) begin
         px.status = ST_RING_OUT;
         return px;
      end
      rate = (keep_rate == 0) ? 1 : keep_rate;
      if (pt.ring % rate != 0) begin
         px.status = ST_DOWNSAMPLED;
         return px;
      end
      ang = bearing_turns(x, y);
      p = (ang - ANG_QUARTER) * COLUMNS;
      if (p >= 0) r = (p + ANG_HALF) >>> 32;
      else r = -((-p + ANG_HALF) >>> 32);
      col = COLUMNS / 2 - r;
      if (col >= COLUMNS) col = col - COLUMNS;
      if (col < 0 || col >= COLUMNS) begin
         px.status = ST_COLUMN_OUT;
         return px;
      end
      idx = int'(col) + pt.ring * COLUMNS;
      px.column = col[11:0];
      if (cell_taken[idx]) begin
         px.status = ST_OCCUPIED;
         return px;
      end
      cell_taken[idx] = 1'b1;
      px.status = ST_KEPT;
      px.cell_index = idx[19:0];
      return px;
   endfunction

   task automatic csr_write(csr_reg_type which, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(which) << 2; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (which)
         CSR_MIN_RANGE:  win_min = value[23:0];
         CSR_MAX_RANGE:  win_max = value[23:0];
         default:        keep_rate = value[4:0];
      endcase
   endtask

   task automatic set_window(logic [23:0] lo, logic [23:0] hi, logic [4:0] rate);
      req.valid <= 1'b0;
      while (expect_wr != expect_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(CSR_MIN_RANGE, lo);
      csr_write(CSR_MAX_RANGE, hi);
      csr_write(CSR_DOWNSAMPLE, rate);
   endtask

   // Sends one request; the expectation is stored at its transfer.
   task automatic send_point(point_type pt, bit typed, pixel_type want);
      pixel_type px;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req.valid <= 1'b1; req.action <= pt.action;
      req.point_x <= pt.x; req.point_y <= pt.y; req.point_z <= pt.z;
      req.ring <= pt.ring;
      do @(posedge clock); while (!req.ready);
      px = project_point(pt);
      if (typed && px !== want) begin
         $display("%0t predictor disagrees with table: expected %h actual %h",
                  $time, want, px);
         errors++;
      end
      expect_mem[expect_wr % EXPECT_DEPTH] = typed ? want : px;
      expect_wr++;
      if (pt.action == ACT_SCAN) scans_sent++; else points_sent++;
   endtask

   function automatic point_type random_point(int mode);
      point_type pt;
      int dir;
      pt.action = ACT_POINT;
      pt.ring = 8'($urandom_range(0, 19));
      case (mode)
         0: begin
            pt.x = 24'($urandom_range(0, 200000)) - 24'sd100000;
            pt.y = 24'($urandom_range(0, 200000)) - 24'sd100000;
            pt.z = 24'($urandom_range(0, 8000)) - 24'sd4000;
         end
         1: begin
            // A few fixed directions so that cells collide.
            dir = $urandom_range(0, 7);
            pt.x = 24'(((dir & 1) ? 3000 : -3000) * (1 + dir / 2));
            pt.y = 24'(((dir & 2) ? 5000 : -2000) * (1 + dir / 2));
            pt.z = 24'($urandom_range(0, 100));
            pt.ring = 8'($urandom_range(0, 15));
         end
         default: begin
            pt.x = 24'($urandom); pt.y = 24'($urandom); pt.z = 24'($urandom);
            pt.ring = 8'($urandom);
         end
      endcase
      return pt;
   endfunction

   // Result checking.
   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.status, rsp.row, rsp.column, rsp.range, rsp.cell_index};
         if (expect_wr == expect_rd) begin
            $display("%0t unexpected result: expected none actual %h", $time, got);
            errors++;
         end else begin
            want = expect_mem[expect_rd % EXPECT_DEPTH];
            expect_rd++;
            if (got.status == ST_KEPT) kept_seen++;
            if (got.status == ST_OCCUPIED) occupied_seen++;
            if (got.status !== want.status) begin
               $display("%0t status: expected %0d actual %0d", $time, want.status,
                        got.status); errors++;
            end
            if (got.row !== want.row) begin
               $display("%0t row: expected %0d actual %0d", $time, want.row, got.row);
               errors++;
            end
            if (got.column !== want.column) begin
               $display("%0t column: expected %0d actual %0d", $time, want.column,
                        got.column); errors++;
            end
            if (got.range !== want.range) begin
               $display("%0t range: expected %0d actual %0d", $time, want.range,
                        got.range); errors++;
            end
            if (got.cell_index !== want.cell_index) begin
               $display("%0t cell_index: expected %0d actual %0d", $time,
                        want.cell_index, got.cell_index); errors++;
            end
         end
      end
   end

   // Receiver stalls come in bursts.
   always @(posedge clock) begin
      if (quiet) begin
         rsp.ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp.ready <= ~rsp.ready;
         rsp_hold <= $urandom_range(1, 19);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   stim_row_type directed [] = '{
      // New scan after reset.
      '{'{ACT_SCAN, 24'sd0, 24'sd0, 24'sd0, 8'd0}, 1'b1,
        '{ST_CLEARED, 8'd0, 12'd0, 24'd0, 20'd0}},
      // Origin falls below the minimum range.
      '{'{ACT_POINT, 24'sd0, 24'sd0, 24'sd0, 8'd0}, 1'b1,
        '{ST_RANGE_OUT, 8'd0, 12'd0, 24'd0, 20'd0}},
      // Ring beyond the image.
      '{'{ACT_POINT, 24'sd2048, 24'sd0, 24'sd0, 8'd255}, 1'b1,
        '{ST_RING_OUT, 8'd255, 12'd0, 24'd2048, 20'd0}},
      '{'{ACT_POINT, 24'sd0, 24'sd2048, 24'sd0, 8'd16}, 1'b1,
        '{ST_RING_OUT, 8'd16, 12'd0, 24'd2048, 20'd0}},
      // Most negative coordinates saturate nothing but leave the window.
      '{'{ACT_POINT, -24'sd8388608, -24'sd8388608, -24'sd8388608, 8'd0}, 1'b0, '0},
      '{'{ACT_POINT, 24'sd8388607, 24'sd8388607, 24'sd8388607, 8'd15}, 1'b0, '0},
      '{'{ACT_POINT, 24'sd0, 24'sd5000, 24'sd0, 8'd0}, 1'b0, '0},
      '{'{ACT_POINT, 24'sd0, 24'sd5000, 24'sd0, 8'd0}, 1'b0, '0},
      '{'{ACT_POINT, 24'sd5000, 24'sd0, 24'sd0, 8'd15}, 1'b0, '0},
      '{'{ACT_POINT, -24'sd5000, 24'sd0, 24'sd0, 8'd7}, 1'b0, '0},
      '{'{ACT_POINT, 24'sd0, -24'sd5000, 24'sd0, 8'd3}, 1'b0, '0},
      '{'{ACT_POINT, 24'sd3000, -24'sd3000, 24'sd0, 8'd1}, 1'b0, '0},
      '{'{ACT_POINT, -24'sd3000, -24'sd3000, 24'sd100, 8'd2}, 1'b0, '0},
      '{'{ACT_POINT, 24'sd0, 24'sd0, 24'sd4000, 8'd4}, 1'b0, '0},
      '{'{ACT_POINT, 24'sd0, 24'sd0, 24'sd4000, 8'd4}, 1'b0, '0},
      '{'{ACT_POINT, 24'sd1024, 24'sd0, 24'sd0, 8'd5}, 1'b0, '0},
      '{'{ACT_SCAN, 24'sd0, 24'sd5000, 24'sd0, 8'd0}, 1'b1,
        '{ST_CLEARED, 8'd0, 12'd0, 24'd0, 20'd0}},
      '{'{ACT_POINT, 24'sd0, 24'sd5000, 24'sd0, 8'd0}, 1'b0, '0}
   };

   initial begin
      point_type pt;
      int mode;
      win_min = MIN_RANGE_RESET; win_max = MAX_RANGE_RESET; keep_rate = RATE_RESET;
      foreach (cell_taken[i]) cell_taken[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_point(directed[i].point, directed[i].typed,
                                       directed[i].pixel);
      // Widest window with rate 16, then the zero rate with an inverted window.
      set_window(24'd0, 24'hFFFFFF, 5'd16);
      send_point('{ACT_POINT, 24'sd0, 24'sd0, 24'sd0, 8'd0}, 1'b0, '0);
      send_point('{ACT_POINT, 24'sd100, 24'sd0, 24'sd0, 8'd8}, 1'b0, '0);
      send_point('{ACT_POINT, -24'sd8388608, -24'sd8388608, -24'sd8388608, 8'd0},
                 1'b0, '0);
      set_window(24'd1000, 24'd500, 5'd0);
      send_point('{ACT_POINT, 24'sd700, 24'sd0, 24'sd0, 8'd0}, 1'b1,
                 '{ST_RANGE_OUT, 8'd0, 12'd0, 24'd700, 20'd0});

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_window(MIN_RANGE_RESET, MAX_RANGE_RESET, 5'd0);
            1: set_window(24'd0, 24'hFFFFFF, 5'd1);
            2: set_window(24'd2000, 24'd60000, 5'd3);
            3: set_window(24'd1024, 24'd150000, 5'd2);
            4: set_window(24'hFFFFFF, 24'hFFFFFF, 5'd31);
            5: set_window(24'd500, 24'd200000, 5'd16);
            default: set_window(24'd0, 24'd1024000, 5'd1);
         endcase
         if (phase == 6) quiet = 1'b1;
         for (int n = 0; n < 250; n++) begin
            mode = $urandom_range(0, 99);
            if (mode < 2) pt = '{ACT_SCAN, 24'($urandom), 24'($urandom),
                                 24'($urandom), 8'($urandom)};
            else if (mode < 65) pt = random_point(0);
            else if (mode < 85) pt = random_point(1);
            else pt = random_point(2);
            send_point(pt, 1'b0, '0);
         end
      end
      req.valid <= 1'b0;

      while (expect_wr != expect_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d points and %0d new-scan commands over ten register settings.",
               points_sent, scans_sent);
      $display("Results: %0d kept, %0d landed in taken cells.", kept_seen,
               occupied_seen);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[files.f]
design/rip_pkg.sv
design/rip_req_if.sv
design/rip_rsp_if.sv
design/rip_mag.sv
design/rip_cordic.sv
design/rip_occ.sv
design/range_image_projection_core.sv
test/range_image_projection_core_tb.sv
